// ----- hdl/packet_request_reply_queue_ctrl_defines.svh -----
// ----------------------------------------------------------------------------
// Request/reply queue controller assertion macros
// Shared property wrappers; clock and reset are the top level's port names.
// ----------------------------------------------------------------------------
`ifndef PACKET_REQUEST_REPLY_QUEUE_CTRL_DEFINES_SVH
`define PACKET_REQUEST_REPLY_QUEUE_CTRL_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PRRQ_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define PRRQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/prrq_pkg.sv -----
// ----------------------------------------------------------------------------
// Request/reply queue controller package
// Event codes, field widths and the length clamp.
// ----------------------------------------------------------------------------
package prrq_pkg;

   localparam int CMD_WIDTH    = 2;
   localparam int LEN_WIDTH    = 7;
   localparam int SLOT_WIDTH   = 3;
   localparam int CNT_WIDTH    = 8;
   localparam int PACKET_BYTES = 64;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_RESET_QUEUES = 2'd0,
      CMD_PKT_RECEIVED = 2'd1,
      CMD_TX_DONE      = 2'd2,
      CMD_PROCESS      = 2'd3
   } cmd_type;

   // clamp a length to the largest packet
   function automatic logic [LEN_WIDTH-1:0] sat_len(input logic [LEN_WIDTH-1:0] v);
      return ({1'b0, v} > CNT_WIDTH'(PACKET_BYTES)) ? LEN_WIDTH'(PACKET_BYTES) : v;
   endfunction

endpackage

// ----- hdl/packet_request_reply_queue_ctrl.sv -----
// ----------------------------------------------------------------------------
// Request/reply queue controller
// Descriptor bookkeeping for a request ring and a reply ring, one event per item.
// ----------------------------------------------------------------------------
// Usage:
//   req_* channel carries one event per item: req_cmd picks reset queues,
//   packet received, transmit done or process one request; req_rx_length and
//   req_reply_length carry the lengths used by those events.
//   rsp_* channel returns exactly one item per event: receiver arm and
//   handshake writes, the reply upload started (if any) and the request popped
//   (if any), plus the slot the receiver now points at.
//   An accepted item is held in the input register, evaluated in one pass
//   and lands in the result register, from which its result is offered.
//   Throughput is 1 item per cycle while rsp_ready stays high; the ring
//   pointers, counters and the length memories' read ports are all updated
//   in that single pass.
//   Reset (synchronous, active high) empties both rings, marks receiver and
//   sender idle and drops any item in flight. A reset-queues event does the
//   same to the rings and answers with slot 0 armed with ACK.
//   When the receiver stalls rsp_ready, the result holds in its register;
//   the input register still takes one more item, then req_ready drops.
//   The length memories need no clearing pass: only written slots are read.
// ----------------------------------------------------------------------------
`include "packet_request_reply_queue_ctrl_defines.svh"

module packet_request_reply_queue_ctrl
   import prrq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CMD_WIDTH-1:0]  req_cmd,
   input  logic [LEN_WIDTH-1:0]  req_rx_length,
   input  logic [LEN_WIDTH-1:0]  req_reply_length,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_rx_arm,
   output logic [SLOT_WIDTH-1:0] rsp_rx_slot,
   output logic                  rsp_rx_handshake_write,
   output logic                  rsp_rx_ack,
   output logic                  rsp_upload_valid,
   output logic [SLOT_WIDTH-1:0] rsp_upload_slot,
   output logic [LEN_WIDTH-1:0]  rsp_upload_length,
   output logic                  rsp_request_valid,
   output logic [SLOT_WIDTH-1:0] rsp_request_slot,
   output logic [LEN_WIDTH-1:0]  rsp_request_length,
   output logic [SLOT_WIDTH-1:0] rsp_reply_slot
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam logic [CNT_WIDTH-1:0] DEPTH_CNT = CNT_WIDTH'(QUEUE_DEPTH);

   // wrap a ring index at the queue depth
   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // input register
   // ---------------------------------------------------------------------
   logic                 in_valid_ff;
   cmd_type              in_cmd_ff;
   logic [LEN_WIDTH-1:0] in_rx_len_ff;
   logic [LEN_WIDTH-1:0] in_reply_len_ff;

   logic rsp_valid_ff;
   logic advance;

   // move the held item into the result register when that register frees up
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_cmd_ff       <= cmd_type'(req_cmd);
         in_rx_len_ff    <= req_rx_length;
         in_reply_len_ff <= req_reply_length;
      end
   end

   // ---------------------------------------------------------------------
   // ring state
   // ---------------------------------------------------------------------
   logic [IDX_W-1:0]     req_wr_idx_ff, req_wr_idx_in;
   logic [IDX_W-1:0]     req_rd_idx_ff, req_rd_idx_in;
   logic [IDX_W-1:0]     rep_wr_idx_ff, rep_wr_idx_in;
   logic [IDX_W-1:0]     rep_rd_idx_ff, rep_rd_idx_in;
   logic [CNT_WIDTH-1:0] req_push_ff, req_push_in;
   logic [CNT_WIDTH-1:0] req_pop_ff, req_pop_in;
   logic [CNT_WIDTH-1:0] rep_push_ff, rep_push_in;
   logic [CNT_WIDTH-1:0] rep_pop_ff, rep_pop_in;
   logic                 receiver_idle_ff, receiver_idle_in;
   logic                 sender_idle_ff, sender_idle_in;

   // length memories: registered read of the slot at each ring's read index
   logic [LEN_WIDTH-1:0] req_mem [QUEUE_DEPTH];
   logic [LEN_WIDTH-1:0] rep_mem [QUEUE_DEPTH];
   logic [LEN_WIDTH-1:0] req_rd_data_ff;
   logic [LEN_WIDTH-1:0] rep_rd_data_ff;
   logic                 req_we, rep_we;
   logic [LEN_WIDTH-1:0] rx_len_sat, reply_len_sat;

   // ---------------------------------------------------------------------
   // event evaluation
   // ---------------------------------------------------------------------
   logic [CNT_WIDTH-1:0] req_fill;
   logic                 req_full_now, req_full_after_push, req_full_after_pop;
   logic                 rep_pending_after_push;
   logic [LEN_WIDTH-1:0] rep_head;

   logic                 res_rx_arm, res_rx_hs, res_rx_ack;
   logic                 res_up_valid, res_req_valid;
   logic [SLOT_WIDTH-1:0] res_up_slot, res_req_slot, res_reply_slot;
   logic [LEN_WIDTH-1:0] res_up_len, res_req_len;

   assign rx_len_sat    = sat_len(in_rx_len_ff);
   assign reply_len_sat = sat_len(in_reply_len_ff);

   assign req_fill            = req_push_ff - req_pop_ff;
   assign req_full_now        = req_fill >= DEPTH_CNT;
   assign req_full_after_push = CNT_WIDTH'(req_fill + 1'b1) >= DEPTH_CNT;
   assign req_full_after_pop  = CNT_WIDTH'(req_fill - 1'b1) >= DEPTH_CNT;
   assign rep_pending_after_push = CNT_WIDTH'(rep_push_ff + 1'b1) != rep_pop_ff;

   // a reply written by this event may be the one sent right away
   assign rep_head = (in_cmd_ff == CMD_PROCESS && rep_wr_idx_ff == rep_rd_idx_ff) ?
                     reply_len_sat : rep_rd_data_ff;

   always_comb begin
      req_wr_idx_in    = req_wr_idx_ff;
      req_rd_idx_in    = req_rd_idx_ff;
      rep_wr_idx_in    = rep_wr_idx_ff;
      rep_rd_idx_in    = rep_rd_idx_ff;
      req_push_in      = req_push_ff;
      req_pop_in       = req_pop_ff;
      rep_push_in      = rep_push_ff;
      rep_pop_in       = rep_pop_ff;
      receiver_idle_in = receiver_idle_ff;
      sender_idle_in   = sender_idle_ff;
      req_we           = 1'b0;
      rep_we           = 1'b0;
      res_rx_arm       = 1'b0;
      res_rx_hs        = 1'b0;
      res_rx_ack       = 1'b0;
      res_up_valid     = 1'b0;
      res_up_slot      = '0;
      res_up_len       = '0;
      res_req_valid    = 1'b0;
      res_req_slot     = '0;
      res_req_len      = '0;
      res_reply_slot   = '0;
      if (advance) begin
         unique case (in_cmd_ff)
            CMD_RESET_QUEUES: begin
               req_wr_idx_in    = '0;
               req_rd_idx_in    = '0;
               rep_wr_idx_in    = '0;
               rep_rd_idx_in    = '0;
               req_push_in      = '0;
               req_pop_in       = '0;
               rep_push_in      = '0;
               rep_pop_in       = '0;
               receiver_idle_in = 1'b1;
               sender_idle_in   = 1'b1;
               res_rx_arm       = 1'b1;
               res_rx_hs        = 1'b1;
               res_rx_ack       = 1'b1;
            end
            CMD_PKT_RECEIVED: begin
               // a full ring drops the packet event; its result item carries no receiver writes
               if (!req_full_now) begin
                  req_we        = 1'b1;
                  req_wr_idx_in = next_slot(req_wr_idx_ff);
                  req_push_in   = req_push_ff + 1'b1;
                  res_rx_hs     = 1'b1;
                  if (!req_full_after_push) begin
                     res_rx_arm = 1'b1;
                     res_rx_ack = 1'b1;
                  end else begin
                     receiver_idle_in = 1'b1;
                  end
               end
            end
            CMD_TX_DONE: begin
               if (rep_push_ff != rep_pop_ff) begin
                  res_up_valid  = 1'b1;
                  res_up_slot   = SLOT_WIDTH'(rep_rd_idx_ff);
                  res_up_len    = rep_head;
                  rep_rd_idx_in = next_slot(rep_rd_idx_ff);
                  rep_pop_in    = rep_pop_ff + 1'b1;
               end else begin
                  sender_idle_in = 1'b1;
               end
            end
            CMD_PROCESS: begin
               if (req_push_ff != req_pop_ff) begin
                  res_req_valid  = 1'b1;
                  res_req_slot   = SLOT_WIDTH'(req_rd_idx_ff);
                  res_req_len    = req_rd_data_ff;
                  res_reply_slot = SLOT_WIDTH'(rep_wr_idx_ff);
                  rep_we         = 1'b1;
                  req_rd_idx_in  = next_slot(req_rd_idx_ff);
                  req_pop_in     = req_pop_ff + 1'b1;
                  // re-arm a receiver that paused on a full ring
                  if (receiver_idle_ff && !req_full_after_pop) begin
                     receiver_idle_in = 1'b0;
                     res_rx_arm       = 1'b1;
                     res_rx_hs        = 1'b1;
                     res_rx_ack       = 1'b1;
                  end
                  rep_wr_idx_in = next_slot(rep_wr_idx_ff);
                  rep_push_in   = rep_push_ff + 1'b1;
                  // kick an idle sender
                  if (sender_idle_ff && rep_pending_after_push) begin
                     sender_idle_in = 1'b0;
                     res_up_valid   = 1'b1;
                     res_up_slot    = SLOT_WIDTH'(rep_rd_idx_ff);
                     res_up_len     = rep_head;
                     rep_rd_idx_in  = next_slot(rep_rd_idx_ff);
                     rep_pop_in     = rep_pop_ff + 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_wr_idx_ff    <= '0;
         req_rd_idx_ff    <= '0;
         rep_wr_idx_ff    <= '0;
         rep_rd_idx_ff    <= '0;
         req_push_ff      <= '0;
         req_pop_ff       <= '0;
         rep_push_ff      <= '0;
         rep_pop_ff       <= '0;
         receiver_idle_ff <= 1'b1;
         sender_idle_ff   <= 1'b1;
      end else begin
         req_wr_idx_ff    <= req_wr_idx_in;
         req_rd_idx_ff    <= req_rd_idx_in;
         rep_wr_idx_ff    <= rep_wr_idx_in;
         rep_rd_idx_ff    <= rep_rd_idx_in;
         req_push_ff      <= req_push_in;
         req_pop_ff       <= req_pop_in;
         rep_push_ff      <= rep_push_in;
         rep_pop_ff       <= rep_pop_in;
         receiver_idle_ff <= receiver_idle_in;
         sender_idle_ff   <= sender_idle_in;
      end
   end

   // prefetch the slot at the next read index; forward a same-cycle write
   always_ff @(posedge clock) begin
      if (req_we) begin
         req_mem[req_wr_idx_ff] <= rx_len_sat;
      end
      if (req_we && req_wr_idx_ff == req_rd_idx_in) begin
         req_rd_data_ff <= rx_len_sat;
      end else begin
         req_rd_data_ff <= req_mem[req_rd_idx_in];
      end
   end

   always_ff @(posedge clock) begin
      if (rep_we) begin
         rep_mem[rep_wr_idx_ff] <= reply_len_sat;
      end
      if (rep_we && rep_wr_idx_ff == rep_rd_idx_in) begin
         rep_rd_data_ff <= reply_len_sat;
      end else begin
         rep_rd_data_ff <= rep_mem[rep_rd_idx_in];
      end
   end

   // ---------------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------------
   logic                  rx_arm_ff, rx_hs_ff, rx_ack_ff;
   logic [SLOT_WIDTH-1:0] rx_slot_ff;
   logic                  up_valid_ff, req_valid_out_ff;
   logic [SLOT_WIDTH-1:0] up_slot_ff, req_slot_ff, reply_slot_ff;
   logic [LEN_WIDTH-1:0]  up_len_ff, req_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rx_arm_ff        <= res_rx_arm;
         rx_slot_ff       <= SLOT_WIDTH'(req_wr_idx_in);
         rx_hs_ff         <= res_rx_hs;
         rx_ack_ff        <= res_rx_ack;
         up_valid_ff      <= res_up_valid;
         up_slot_ff       <= res_up_slot;
         up_len_ff        <= res_up_len;
         req_valid_out_ff <= res_req_valid;
         req_slot_ff      <= res_req_slot;
         req_len_ff       <= res_req_len;
         reply_slot_ff    <= res_reply_slot;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_rx_arm             = rx_arm_ff;
   assign rsp_rx_slot            = rx_slot_ff;
   assign rsp_rx_handshake_write = rx_hs_ff;
   assign rsp_rx_ack             = rx_ack_ff;
   assign rsp_upload_valid       = up_valid_ff;
   assign rsp_upload_slot        = up_slot_ff;
   assign rsp_upload_length      = up_len_ff;
   assign rsp_request_valid      = req_valid_out_ff;
   assign rsp_request_slot       = req_slot_ff;
   assign rsp_request_length     = req_len_ff;
   assign rsp_reply_slot         = reply_slot_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   `PRRQ_ASSERT_IMPLY(a_req_fill_bound, 1'b1, req_fill <= DEPTH_CNT, "request ring overfilled")
   `PRRQ_ASSERT_IMPLY(a_idle_sender_empty, sender_idle_ff,
                      rep_push_ff == rep_pop_ff, "idle sender with pending reply")
   `PRRQ_ASSERT_NEXT(a_advance_shows_result, advance, rsp_valid_ff, "advanced item not presented")

endmodule

// ----- tb/sv/prrq_ring_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request/reply ring tracker
// Watches both channels of the queue controller, predicts every result item
// from its own copy of the two rings and compares results in order.
// ----------------------------------------------------------------------------
module prrq_ring_tracker
   import prrq_pkg::*;
#(
   parameter int DEPTH        = 8,
   parameter int REPORT_LIMIT = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [CMD_WIDTH-1:0]  req_cmd,
   input  logic [LEN_WIDTH-1:0]  req_rx_length,
   input  logic [LEN_WIDTH-1:0]  req_reply_length,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_rx_arm,
   input  logic [SLOT_WIDTH-1:0] rsp_rx_slot,
   input  logic                  rsp_rx_handshake_write,
   input  logic                  rsp_rx_ack,
   input  logic                  rsp_upload_valid,
   input  logic [SLOT_WIDTH-1:0] rsp_upload_slot,
   input  logic [LEN_WIDTH-1:0]  rsp_upload_length,
   input  logic                  rsp_request_valid,
   input  logic [SLOT_WIDTH-1:0] rsp_request_slot,
   input  logic [LEN_WIDTH-1:0]  rsp_request_length,
   input  logic [SLOT_WIDTH-1:0] rsp_reply_slot,
   output int                    fail_count,
   output int                    pending_count
);

   typedef struct packed {
      logic                  rx_arm;
      logic [SLOT_WIDTH-1:0] rx_slot;
      logic                  rx_handshake_write;
      logic                  rx_ack;
      logic                  upload_valid;
      logic [SLOT_WIDTH-1:0] upload_slot;
      logic [LEN_WIDTH-1:0]  upload_length;
      logic                  request_valid;
      logic [SLOT_WIDTH-1:0] request_slot;
      logic [LEN_WIDTH-1:0]  request_length;
      logic [SLOT_WIDTH-1:0] reply_slot;
   } ring_result_type;

   // shadow copy of both rings
   logic [SLOT_WIDTH-1:0] rq_wr, rq_rd, rp_wr, rp_rd;
   logic [CNT_WIDTH-1:0]  rq_pushes, rq_pops, rp_pushes, rp_pops;
   logic                  rx_paused, tx_paused;
   logic [LEN_WIDTH-1:0]  rq_len_mem [DEPTH];
   logic [LEN_WIDTH-1:0]  rp_len_mem [DEPTH];

   ring_result_type pending_results [$];
   ring_result_type want, got;
   logic            bad;
   int              failures = 0;
   int              backlog  = 0;

   assign fail_count    = failures;
   assign pending_count = backlog;

   function automatic void clear_rings();
      rq_wr     = '0;
      rq_rd     = '0;
      rp_wr     = '0;
      rp_rd     = '0;
      rq_pushes = '0;
      rq_pops   = '0;
      rp_pushes = '0;
      rp_pops   = '0;
      rx_paused = 1'b1;
      tx_paused = 1'b1;
      for (int i = 0; i < DEPTH; i++) begin
         rq_len_mem[i] = '0;
         rp_len_mem[i] = '0;
      end
   endfunction

   function automatic logic request_ring_full();
      logic [CNT_WIDTH-1:0] fill;
      fill = rq_pushes - rq_pops;
      return fill >= DEPTH;
   endfunction

   function automatic logic [LEN_WIDTH-1:0] clamp_length(input logic [LEN_WIDTH-1:0] v);
      if (v > PACKET_BYTES) return LEN_WIDTH'(PACKET_BYTES);
      return v;
   endfunction

   function automatic void launch_upload(inout ring_result_type r);
      r.upload_valid  = 1'b1;
      r.upload_slot   = rp_rd;
      r.upload_length = rp_len_mem[rp_rd];
      rp_rd   = rp_rd + 1'b1;
      rp_pops = rp_pops + 1'b1;
   endfunction

   // apply one event to the shadow rings and return the result item it causes
   function automatic ring_result_type predict_event(input cmd_type c,
                                                     input logic [LEN_WIDTH-1:0] rx_len,
                                                     input logic [LEN_WIDTH-1:0] rep_len);
      ring_result_type r;
      r = '0;
      case (c)
         CMD_RESET_QUEUES: begin
            clear_rings();
            r.rx_arm             = 1'b1;
            r.rx_handshake_write = 1'b1;
            r.rx_ack             = 1'b1;
         end
         CMD_PKT_RECEIVED: begin
            if (!request_ring_full()) begin
               rq_len_mem[rq_wr]    = clamp_length(rx_len);
               rq_wr                = rq_wr + 1'b1;
               rq_pushes            = rq_pushes + 1'b1;
               r.rx_handshake_write = 1'b1;
               if (!request_ring_full()) begin
                  r.rx_arm = 1'b1;
                  r.rx_ack = 1'b1;
               end else begin
                  rx_paused = 1'b1;
               end
            end
         end
         CMD_TX_DONE: begin
            if (rp_pushes != rp_pops) launch_upload(r);
            else tx_paused = 1'b1;
         end
         default: begin
            if (rq_pushes != rq_pops) begin
               r.request_valid    = 1'b1;
               r.request_slot     = rq_rd;
               r.request_length   = rq_len_mem[rq_rd];
               r.reply_slot       = rp_wr;
               rp_len_mem[rp_wr]  = clamp_length(rep_len);
               rq_rd              = rq_rd + 1'b1;
               rq_pops            = rq_pops + 1'b1;
               if (rx_paused && !request_ring_full()) begin
                  rx_paused            = 1'b0;
                  r.rx_arm             = 1'b1;
                  r.rx_handshake_write = 1'b1;
                  r.rx_ack             = 1'b1;
               end
               rp_wr     = rp_wr + 1'b1;
               rp_pushes = rp_pushes + 1'b1;
               if (tx_paused && rp_pushes != rp_pops) begin
                  tx_paused = 1'b0;
                  launch_upload(r);
               end
            end
         end
      endcase
      r.rx_slot = rq_wr;
      return r;
   endfunction

   function automatic string describe_result(input ring_result_type r);
      return $sformatf({"arm=%0d rx_slot=%0d hs_wr=%0d ack=%0d up=%0d/%0d/%0d ",
                        "req=%0d/%0d/%0d reply_slot=%0d"},
                       r.rx_arm, r.rx_slot, r.rx_handshake_write, r.rx_ack,
                       r.upload_valid, r.upload_slot, r.upload_length,
                       r.request_valid, r.request_slot, r.request_length,
                       r.reply_slot);
   endfunction

   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_rings();
         pending_results.delete();
      end else begin
         // compare first so an item accepted this edge cannot hide a stray result
         if (rsp_valid && rsp_ready) begin
            got.rx_arm             = rsp_rx_arm;
            got.rx_slot            = rsp_rx_slot;
            got.rx_handshake_write = rsp_rx_handshake_write;
            got.rx_ack             = rsp_rx_ack;
            got.upload_valid       = rsp_upload_valid;
            got.upload_slot        = rsp_upload_slot;
            got.upload_length      = rsp_upload_length;
            got.request_valid      = rsp_request_valid;
            got.request_slot       = rsp_request_slot;
            got.request_length     = rsp_request_length;
            got.reply_slot         = rsp_reply_slot;
            if (pending_results.size() == 0) begin
               note_failure({"result item with no event waiting: ", describe_result(got)});
            end else begin
               want = pending_results.pop_front();
               bad = (got.rx_arm             !== want.rx_arm)             ||
                     (got.rx_slot            !== want.rx_slot)            ||
                     (got.rx_handshake_write !== want.rx_handshake_write) ||
                     (got.rx_ack             !== want.rx_ack)             ||
                     (got.upload_valid       !== want.upload_valid)       ||
                     (got.upload_slot        !== want.upload_slot)        ||
                     (got.upload_length      !== want.upload_length)      ||
                     (got.request_valid      !== want.request_valid)      ||
                     (got.request_slot       !== want.request_slot)       ||
                     (got.request_length     !== want.request_length)     ||
                     (got.reply_slot         !== want.reply_slot);
               if (bad) begin
                  note_failure($sformatf("result mismatch\n   expected %s\n   actual   %s",
                                         describe_result(want), describe_result(got)));
               end
            end
         end
         if (req_valid && req_ready) begin
            pending_results.push_back(predict_event(cmd_type'(req_cmd), req_rx_length,
                                                    req_reply_length));
         end
      end
      backlog = pending_results.size();
   end

endmodule

// ----- tb/sv/packet_request_reply_queue_ctrl_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request/reply queue controller testbench
// Drives directed and random events into the controller with random idle
// bursts on both channels, plus one long result stall that backs up the
// input; the ring tracker beside the block predicts and checks every result.
// ----------------------------------------------------------------------------
module packet_request_reply_queue_ctrl_test;
   import prrq_pkg::*;

   localparam int RANDOM_EVENTS   = 950;
   localparam int MIX_BLOCK       = 50;   // events per random traffic mix
   localparam int CALM_TAIL       = 150;  // last events run without idling
   localparam int PRESSURE_AT     = 300;  // events sent before the long stall
   localparam int PRESSURE_CYCLES = 300;
   localparam int STALL_LIMIT     = 3000; // cycles with no handshake at all
   localparam int DRAIN_CYCLES    = 6;

   // traffic mixes for the random part
   typedef enum int {
      MIX_BALANCED,
      MIX_FILL,     // receive heavy: fill the request ring, hit NAK
      MIX_DRAIN,    // process heavy, few transmit-done: overrun the reply ring
      MIX_SEND      // transmit-done heavy: drain replies, idle the sender
   } mix_type;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic [CMD_WIDTH-1:0]  req_cmd          = '0;
   logic [LEN_WIDTH-1:0]  req_rx_length    = '0;
   logic [LEN_WIDTH-1:0]  req_reply_length = '0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic                  rsp_rx_arm;
   logic [SLOT_WIDTH-1:0] rsp_rx_slot;
   logic                  rsp_rx_handshake_write;
   logic                  rsp_rx_ack;
   logic                  rsp_upload_valid;
   logic [SLOT_WIDTH-1:0] rsp_upload_slot;
   logic [LEN_WIDTH-1:0]  rsp_upload_length;
   logic                  rsp_request_valid;
   logic [SLOT_WIDTH-1:0] rsp_request_slot;
   logic [LEN_WIDTH-1:0]  rsp_request_length;
   logic [SLOT_WIDTH-1:0] rsp_reply_slot;

   int      fail_count;
   int      pending_count;
   int      events_sent  = 0;
   int      stall_cycles = 0;
   bit      calm_tail    = 1'b0;
   bit      quiet_block  = 1'b0;
   bit      squeeze_done = 1'b0;
   mix_type mix;

   always #5 clock = ~clock;

   packet_request_reply_queue_ctrl DUT (.*);

   prrq_ring_tracker tracker (.*);

   // mostly legal lengths, sometimes above the largest packet to hit the clamp
   function automatic logic [LEN_WIDTH-1:0] pick_length();
      if ($urandom_range(0, 7) == 0) return LEN_WIDTH'($urandom_range(PACKET_BYTES + 1, 127));
      return LEN_WIDTH'($urandom_range(0, PACKET_BYTES));
   endfunction

   function automatic cmd_type pick_event(input mix_type m);
      int unsigned roll;
      int unsigned rx_top, tx_top;
      roll = $urandom_range(0, 99);
      case (m)
         MIX_FILL:  begin rx_top = 70; tx_top = 85; end
         MIX_DRAIN: begin rx_top = 35; tx_top = 40; end
         MIX_SEND:  begin rx_top = 30; tx_top = 70; end
         default:   begin rx_top = 40; tx_top = 65; end
      endcase
      // queue resets stay rare so the rings get deep between them
      if (roll < 2)      return CMD_RESET_QUEUES;
      if (roll < rx_top) return CMD_PKT_RECEIVED;
      if (roll < tx_top) return CMD_TX_DONE;
      return CMD_PROCESS;
   endfunction

   // offer one item and hold it until the block takes it
   task automatic offer_event(input cmd_type c, input logic [LEN_WIDTH-1:0] rx_len,
                              input logic [LEN_WIDTH-1:0] rep_len);
      req_valid        <= 1'b1;
      req_cmd          <= c;
      req_rx_length    <= rx_len;
      req_reply_length <= rep_len;
      do @(posedge clock); while (!req_ready);
      events_sent++;
   endtask

   // drop valid for a random burst now and then
   task automatic maybe_pause();
      if (!calm_tail && !quiet_block && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // result side: random ready bursts, one long hold-off, then always ready
   initial begin
      wait (!reset);
      @(posedge clock);
      forever begin
         if (calm_tail) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else if (!squeeze_done && events_sent >= PRESSURE_AT) begin
            // hold results back long enough for the input side to stall
            rsp_ready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(posedge clock);
            squeeze_done = 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   // end the run if neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: queue reset, empty-ring events, fill to NAK, overfill,
      // drain with upload restart, clamped lengths, mid-run queue reset
      offer_event(CMD_RESET_QUEUES, 7'd0, 7'd0);
      offer_event(CMD_TX_DONE,      7'd127, 7'd127);
      offer_event(CMD_PROCESS,      7'd0, 7'd127);
      offer_event(CMD_PKT_RECEIVED, 7'd0, 7'd0);
      offer_event(CMD_PKT_RECEIVED, 7'd1, 7'd0);
      offer_event(CMD_PKT_RECEIVED, 7'd63, 7'd0);
      offer_event(CMD_PKT_RECEIVED, 7'd64, 7'd0);
      maybe_pause();
      offer_event(CMD_PKT_RECEIVED, 7'd65, 7'd0);
      offer_event(CMD_PKT_RECEIVED, 7'd127, 7'd0);
      offer_event(CMD_PKT_RECEIVED, 7'd85, 7'd0);
      offer_event(CMD_PKT_RECEIVED, 7'd42, 7'd0);   // fills the ring: NAK
      offer_event(CMD_PKT_RECEIVED, 7'd33, 7'd0);   // full ring: ignored
      offer_event(CMD_PROCESS,      7'd0, 7'd127);  // re-arms and starts upload
      offer_event(CMD_PROCESS,      7'd127, 7'd0);
      maybe_pause();
      offer_event(CMD_TX_DONE,      7'd0, 7'd0);
      offer_event(CMD_TX_DONE,      7'd0, 7'd0);
      offer_event(CMD_TX_DONE,      7'd0, 7'd0);    // nothing pending: sender idles
      offer_event(CMD_PROCESS,      7'd0, 7'd65);   // restarts the idle sender
      offer_event(CMD_PROCESS,      7'd0, 7'd64);
      offer_event(CMD_RESET_QUEUES, 7'd127, 7'd127);
      offer_event(CMD_PKT_RECEIVED, 7'd127, 7'd127);
      maybe_pause();

      for (int i = 0; i < RANDOM_EVENTS; i++) begin
         if (i % MIX_BLOCK == 0) begin
            mix         = mix_type'($urandom_range(0, 3));
            quiet_block = ($urandom_range(0, 3) == 0);
         end
         calm_tail = (i >= RANDOM_EVENTS - CALM_TAIL);
         offer_event(pick_event(mix), pick_length(), pick_length());
         maybe_pause();
      end
      req_valid <= 1'b0;

      // let the last item land in the tracker, then wait out the results
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
